// File: src/scc_pkg.sv
package scc_pkg;

    localparam int unsigned FRAME_BYTES  = 9;
    localparam int unsigned POS_W        = 4;
    localparam logic [7:0]  CRC_POLY_REF = 8'h8C;
    localparam logic [7:0]  WARMUP_RESET = 8'd2;
    localparam logic [7:0]  COUNT_MAX    = 8'hFF;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BYTES);

    typedef enum logic [1:0] {
        ST_TEMP_OK  = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_WARMUP   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_sixteenths;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    // reflected CRC-8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REF;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/scc_frame_core.sv
module scc_frame_core
    import scc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic     i_step,
    input  t_in_item i_item,
    output t_result  o_result
);

    logic [7:0]       r_warmup;
    logic [7:0]       r_crc;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_temp_lo;
    logic [7:0]       r_temp_hi;
    logic [7:0]       r_good_cnt;

    logic [7:0]       n_crc;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_temp_lo;
    logic [7:0]       n_temp_hi;
    logic [7:0]       n_good_cnt;

    logic [POS_W-1:0] pos_eff;
    logic [7:0]       crc_base;
    logic             report;

    assign pos_eff  = (i_item.frame_start || (r_pos >= POS_LIMIT)) ? POS_FIRST : r_pos;
    assign crc_base = (pos_eff == POS_FIRST) ? 8'd0 : r_crc;
    assign report   = (r_good_cnt >= r_warmup);

    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_temp_lo  = r_temp_lo;
        n_temp_hi  = r_temp_hi;
        n_good_cnt = r_good_cnt;
        o_result   = '0;
        if (i_step) begin
            if (pos_eff < POS_CHECK) begin
                if (pos_eff == POS_FIRST) begin
                    n_temp_lo = i_item.data_byte;
                end
                if (pos_eff == POS_HIGH) begin
                    n_temp_hi = i_item.data_byte;
                end
                n_crc = crc8_step(crc_base, i_item.data_byte);
                n_pos = pos_eff + POS_W'(1);
            end else begin
                n_pos          = POS_FIRST;
                n_crc          = 8'd0;
                o_result.valid = 1'b1;
                if (crc_base != i_item.data_byte) begin
                    o_result.item.status = ST_CRC_ERR;
                end else begin
                    if (r_good_cnt != COUNT_MAX) begin
                        n_good_cnt = r_good_cnt + 8'd1;
                    end
                    if (report) begin
                        o_result.item.status                 = ST_TEMP_OK;
                        o_result.item.temperature_sixteenths = {r_temp_hi, r_temp_lo};
                    end else begin
                        o_result.item.status = ST_WARMUP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup   <= WARMUP_RESET;
            r_crc      <= 8'd0;
            r_pos      <= POS_FIRST;
            r_temp_lo  <= 8'd0;
            r_temp_hi  <= 8'd0;
            r_good_cnt <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_warmup <= i_cfg_wr_data;
            end
            r_crc      <= n_crc;
            r_pos      <= n_pos;
            r_temp_lo  <= n_temp_lo;
            r_temp_hi  <= n_temp_hi;
            r_good_cnt <= n_good_cnt;
        end
    end

endmodule

// File: src/scc_out_buf.sv
module scc_out_buf
    import scc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_result,
    output logic      o_has_space,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_out_item  r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign o_has_space = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_buf[r_rd_ptr];
    assign push        = i_result.valid;
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_result.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/scratchpad_crc8_temperature_check.sv
// Scratchpad CRC-8 temperature check.
// Input channel (i_in_valid / o_in_ready, i_in_item): one scratchpad byte per
// item, frame_start marks byte 0 of a nine-byte frame. Unmarked bytes after a
// ninth byte start the next frame.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per ninth
// byte: temperature in 1/16 degree with status OK, or status CRC error or
// warm-up discard with temperature 0.
// Config: i_cfg_wr_en / i_cfg_wr_data write warmup_frames (reset 2); write
// only while idle.
// Path: a result passes the input register, then frame logic into a
// two-entry output buffer, and is valid once it is in that buffer.
// Throughput: one byte per cycle; the output buffer space seen from the
// registered buffer count is the only thing that holds the input register.
// Receiver stall: the buffer fills, then the input register holds and
// o_in_ready drops; no item is lost.
// Reset (synchronous, active low): frame position, CRC, temperature bytes,
// good-frame count clear, both buffers empty; warmup_frames returns to 2.
module scratchpad_crc8_temperature_check
    import scc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     has_space;
    logic     advance;
    t_result  result;

    assign advance    = r_in_valid && has_space;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    scc_frame_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_item        (r_in_item),
        .o_result      (result)
    );

    scc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_has_space (has_space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
